// ----- rtl/pmx_pkg.sv -----
// pmx_pkg: command and result beat types and the fixed field widths of the
// partially mapped crossover engine. No dependencies.
`timescale 1ns / 1ps

package pmx_pkg;

	localparam int CITY_W = 6;
	localparam int CNT_W  = 7;

	localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_RUN  = 1'b1;

	typedef struct packed {
		logic              action;
		logic [CITY_W-1:0] position;
		logic [CITY_W-1:0] gene_one;
		logic [CITY_W-1:0] gene_two;
		logic [CITY_W-1:0] cut_first;
		logic [CITY_W-1:0] cut_second;
	} cmd_t;

	typedef struct packed {
		logic [CITY_W-1:0] out_position;
		logic [CITY_W-1:0] child_one_gene;
		logic [CITY_W-1:0] child_two_gene;
		logic              last;
		logic              error;
	} res_t;

endpackage

// ----- rtl/pmx_crossover_engine.sv -----
// pmx_crossover_engine: PMX crossover of two parent tours held in block memories.
// Depends on pmx_pkg (cmd_t, res_t, widths, action codes).
//
//  channel   direction  handshake                    beat
//  command   in         start & !busy                cmd_t: load a gene pair or run
//  result    out        strobe, one cycle, no stall  res_t: one child position
//  config    in         cfg_valid & cfg_ready        cfg_data: city_count
//
// A load never makes the block busy; loads may follow each other every cycle.
// A run reads both parent stores per position, and each gene outside the segment
// walks its mapping chain: each step reads the where memory and then the store
// memories, once per child; the emit of all n positions follows.
// A failed run gives its single error result in the cycle after the failure is found.
// Memories have no reset and are undefined until loaded; arst_n clears control only.
// The receiver cannot stall results; busy stays high until the last one is shown.
`timescale 1ns / 1ps

module pmx_crossover_engine
	import pmx_pkg::*;
#(
	parameter int MAX_CITIES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             strobe,
	output res_t             res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_CITIES);
	localparam int WHERE_DEPTH = 1 << CITY_W;
	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_CITIES);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_RD_POS  = 6'b000010,
		S_GOT_POS = 6'b000100,
		S_WHERE   = 6'b001000,
		S_STORE   = 6'b010000,
		S_EMIT    = 6'b100000
	} state_t;

	// memories
	logic [CITY_W-1:0] st1_mem [MAX_CITIES];
	logic [CITY_W-1:0] st2_mem [MAX_CITIES];
	logic [CITY_W-1:0] wh1_mem [WHERE_DEPTH];
	logic [CITY_W-1:0] wh2_mem [WHERE_DEPTH];
	logic [CITY_W-1:0] ch1_mem [MAX_CITIES];
	logic [CITY_W-1:0] ch2_mem [MAX_CITIES];

	logic [CITY_W-1:0] st1_rd, st2_rd, wh1_rd, wh2_rd, ch1_rd, ch2_rd;

	// control registers
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CITY_W-1:0] lo_q, hi_q, k_q, v_q, g2_q, c1_q;
	logic [CNT_W-1:0]  steps_q;
	logic              sd_q;
	logic              em_v_s1, em_last_s1, fail_s1;
	logic [CITY_W-1:0] em_pos_s1;

	// combinational controls
	logic [CNT_W-1:0]  n_act;
	logic [CITY_W-1:0] cut_lo, cut_hi;
	logic [CNT_W-1:0]  limit;
	logic              accept, ld_we, k_last, k_in_seg;
	logic [CITY_W-1:0] p_sel, oth_sel, own_sel;
	logic              p_in_seg;
	logic [AW-1:0]     st_raddr;
	logic [CITY_W-1:0] wh_raddr;
	logic              ch_we;
	logic [CITY_W-1:0] ch1_wd, ch2_wd;
	logic              fail_now;

	// next-k and walk bookkeeping, decided in the comb block
	logic              adv_k, restart_b, walk_step;
	logic [CITY_W-1:0] walk_res;

	always_comb begin
		if (cnt_q < 7'd2) begin
			n_act = 7'd2;
		end else if (cnt_q > MAX_N) begin
			n_act = MAX_N;
		end else begin
			n_act = cnt_q;
		end
	end

	assign cut_lo = (cmd.cut_first < cmd.cut_second) ? cmd.cut_first : cmd.cut_second;
	assign cut_hi = (cmd.cut_first < cmd.cut_second) ? cmd.cut_second : cmd.cut_first;
	assign limit  = {1'b0, hi_q} - {1'b0, lo_q} + 7'd1;

	assign busy      = (state_q != S_IDLE) || em_v_s1 || fail_s1;
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign ld_we     = accept && (cmd.action == ACT_LOAD) && ({1'b0, cmd.position} < MAX_N);

	assign k_last   = ({1'b0, k_q} == (n_act - 7'd1));
	assign k_in_seg = (k_q >= lo_q) && (k_q <= hi_q);

	assign p_sel    = sd_q ? wh1_rd : wh2_rd;
	assign p_in_seg = (p_sel >= lo_q) && (p_sel <= hi_q);
	assign oth_sel  = sd_q ? st1_rd : st2_rd;
	assign own_sel  = sd_q ? st2_rd : st1_rd;

	always_comb begin
		state_d   = state_q;
		st_raddr  = k_q[AW-1:0];
		wh_raddr  = own_sel;
		ch_we     = 1'b0;
		ch1_wd    = c1_q;
		ch2_wd    = v_q;
		fail_now  = 1'b0;
		adv_k     = 1'b0;
		restart_b = 1'b0;
		walk_step = 1'b0;
		walk_res  = v_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (cmd.action == ACT_RUN)) begin
					if ({1'b0, cut_hi} >= n_act) begin
						fail_now = 1'b1;
					end else begin
						state_d = S_RD_POS;
					end
				end
			end
			S_RD_POS: begin
				state_d = S_GOT_POS;
			end
			S_GOT_POS: begin
				if (k_in_seg) begin
					ch_we  = 1'b1;
					ch1_wd = st2_rd;
					ch2_wd = st1_rd;
					adv_k  = 1'b1;
				end else begin
					// side one starts from parent one's gene
					wh_raddr = st1_rd;
					state_d  = S_WHERE;
				end
			end
			S_WHERE: begin
				if (p_in_seg) begin
					st_raddr = p_sel[AW-1:0];
					state_d  = S_STORE;
				end else if (!sd_q) begin
					restart_b = 1'b1;
				end else begin
					ch_we = 1'b1;
					adv_k = 1'b1;
				end
			end
			S_STORE: begin
				if (oth_sel != v_q) begin
					if (!sd_q) begin
						restart_b = 1'b1;
					end else begin
						ch_we = 1'b1;
						adv_k = 1'b1;
					end
				end else if (steps_q >= limit) begin
					fail_now = 1'b1;
					state_d  = S_IDLE;
				end else begin
					walk_step = 1'b1;
					state_d   = S_WHERE;
				end
			end
			S_EMIT: begin
				if (k_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (restart_b) begin
			// side one done; side two starts from parent two's gene
			wh_raddr = g2_q;
			state_d  = S_WHERE;
		end
		if (adv_k) begin
			state_d = k_last ? S_EMIT : S_RD_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= CNT_RESET;
			k_q        <= '0;
			em_v_s1    <= 1'b0;
			em_last_s1 <= 1'b0;
			fail_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cnt_q <= cfg_data;
			end
			if (state_q == S_IDLE) begin
				k_q <= '0;
			end else if (adv_k) begin
				k_q <= k_last ? '0 : k_q + 6'd1;
			end else if (state_q == S_EMIT) begin
				k_q <= k_q + 6'd1;
			end
			em_v_s1    <= (state_q == S_EMIT);
			em_last_s1 <= (state_q == S_EMIT) && k_last;
			fail_s1    <= fail_now;
		end
	end

	// walk payload registers
	always_ff @(posedge clk) begin
		em_pos_s1 <= k_q;
		if (accept && (cmd.action == ACT_RUN)) begin
			lo_q <= cut_lo;
			hi_q <= cut_hi;
		end
		if ((state_q == S_GOT_POS) && !k_in_seg) begin
			g2_q    <= st2_rd;
			v_q     <= st1_rd;
			sd_q    <= 1'b0;
			steps_q <= '0;
		end else if (restart_b) begin
			c1_q    <= walk_res;
			v_q     <= g2_q;
			sd_q    <= 1'b1;
			steps_q <= '0;
		end else if (walk_step) begin
			v_q     <= own_sel;
			steps_q <= steps_q + 7'd1;
		end
	end

	// parent stores: written by loads, read at one address per cycle
	always_ff @(posedge clk) begin
		if (ld_we) begin
			st1_mem[cmd.position[AW-1:0]] <= cmd.gene_one;
		end
		st1_rd <= st1_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			st2_mem[cmd.position[AW-1:0]] <= cmd.gene_two;
		end
		st2_rd <= st2_mem[st_raddr];
	end

	// where memories: position of each city
	always_ff @(posedge clk) begin
		if (ld_we) begin
			wh1_mem[cmd.gene_one] <= cmd.position;
		end
		wh1_rd <= wh1_mem[wh_raddr];
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			wh2_mem[cmd.gene_two] <= cmd.position;
		end
		wh2_rd <= wh2_mem[wh_raddr];
	end

	// child buffers: filled during the walk, drained during emit
	always_ff @(posedge clk) begin
		if (ch_we) begin
			ch1_mem[k_q[AW-1:0]] <= ch1_wd;
		end
		ch1_rd <= ch1_mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ch_we) begin
			ch2_mem[k_q[AW-1:0]] <= ch2_wd;
		end
		ch2_rd <= ch2_mem[k_q[AW-1:0]];
	end

	assign strobe = em_v_s1 || fail_s1;

	always_comb begin
		if (fail_s1) begin
			res = '{out_position: '0, child_one_gene: '0, child_two_gene: '0,
				last: 1'b1, error: 1'b1};
		end else begin
			res = '{out_position: em_pos_s1, child_one_gene: ch1_rd,
				child_two_gene: ch2_rd, last: em_last_s1, error: 1'b0};
		end
	end

endmodule

// ----- rtl/pmx_checker.sv -----
// pmx_checker: port-level assertions for pmx_crossover_engine, bound to the top.
// Depends on pmx_pkg (cmd_t, res_t, action codes).
`timescale 1ns / 1ps

module pmx_checker
	import pmx_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input cmd_t             cmd,
	input logic             strobe,
	input res_t             res
);

	// a result beat is only shown while the run still holds the block
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result beat while not busy");

	// error beat is the lone, final, zeroed result
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.error) |-> (res.last && (res.out_position == '0)
			&& (res.child_one_gene == '0) && (res.child_two_gene == '0)))
		else $error("malformed error beat");

	// child beats come without gaps until last
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !res.last) |=> strobe)
		else $error("gap inside result burst");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.last) |=> !strobe)
		else $error("beat after last");

	// a load never holds the block
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.action == ACT_LOAD)) |=> !busy)
		else $error("load left block busy");

endmodule

bind pmx_crossover_engine pmx_checker u_pmx_checker (.*);

// ----- sim/pmx_crossover_engine_test.sv -----
`timescale 1ns / 1ps
// pmx_crossover_engine_test: self-checking bench for the PMX crossover engine.
// Drives load and run command beats and checks each result beat against a crossover predictor.
// Depends on pmx_pkg and pmx_crossover_engine.

module pmx_crossover_engine_test;
	import pmx_pkg::*;

	localparam int MAX_CITIES  = 64;
	localparam int QUIET_LIMIT = 100000;
	localparam int SETTLE      = 8;
	localparam res_t FAILED_RUN = {6'd0, 6'd0, 6'd0, 1'b1, 1'b1};

	typedef logic [CITY_W-1:0] city_t;
	typedef city_t tour_t [MAX_CITIES];

	typedef struct {
		cmd_t beat;
		bit   typed;
		res_t want;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             cmd;
	logic             strobe;
	res_t             res;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	pmx_crossover_engine #(
		.MAX_CITIES(MAX_CITIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.strobe   (strobe),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// predictor copy of the parents: city per position and position per city
	tour_t            tour_one, tour_two, slot_one, slot_two;
	logic [CNT_W-1:0] city_count;
	res_t             pending_children [$];
	res_t             oldest_child;
	int               mismatches;

	bit   item_typed;
	res_t item_want;
	int   idle_pct, calm_left, items_sent;
	row_t directed_rows [$];

	int plan_count [8] = '{64, 0, 8, 1, 127, 5, 16, 2};
	int plan_idle  [8] = '{0, 65, 28, 0, 65, 0, 28, 65};
	int plan_items [8] = '{70, 35, 40, 20, 60, 30, 40, 30};

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int active_cities();
		if (city_count < 2)
			return 2;
		if (city_count > MAX_CITIES)
			return MAX_CITIES;
		return int'(city_count);
	endfunction

	// follow a city through the segment; 0 when the chain runs longer than the segment
	function automatic bit walk_gene(input city_t seed, input tour_t own, input tour_t oth_tour,
			input tour_t oth_slot, input int lo, input int hi, output city_t mapped);
		city_t v;
		int    p, steps;
		v = seed;
		steps = 0;
		mapped = '0;
		while (1) begin
			p = int'(oth_slot[v]);
			if (p < lo || p > hi || oth_tour[p] != v)
				break;
			steps++;
			if (steps > hi - lo + 1)
				return 1'b0;
			v = own[p];
		end
		mapped = v;
		return 1'b1;
	endfunction

	function automatic void breed_children(input city_t cut_a, input city_t cut_b);
		city_t kid_one [MAX_CITIES];
		city_t kid_two [MAX_CITIES];
		city_t gene;
		int    n, lo, hi, k;
		bit    ok;
		res_t  r;
		n = active_cities();
		lo = int'((cut_a < cut_b) ? cut_a : cut_b);
		hi = int'((cut_a < cut_b) ? cut_b : cut_a);
		ok = (hi < n);
		for (k = 0; k < n && ok; k++) begin
			if (k >= lo && k <= hi) begin
				kid_one[k] = tour_two[k];
				kid_two[k] = tour_one[k];
			end else begin
				ok = walk_gene(tour_one[k], tour_one, tour_two, slot_two, lo, hi, gene);
				kid_one[k] = gene;
				if (ok)
					ok = walk_gene(tour_two[k], tour_two, tour_one, slot_one, lo, hi, gene);
				kid_two[k] = gene;
			end
		end
		if (!ok) begin
			pending_children.push_back(FAILED_RUN);
			return;
		end
		for (k = 0; k < n; k++) begin
			r.out_position   = CITY_W'(k);
			r.child_one_gene = kid_one[k];
			r.child_two_gene = kid_two[k];
			r.last           = (k == n - 1);
			r.error          = 1'b0;
			pending_children.push_back(r);
		end
	endfunction

	task automatic note_mismatch(input string what, input logic [CITY_W-1:0] want,
			input logic [CITY_W-1:0] got);
		mismatches++;
		$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				if (cmd.action == ACT_LOAD) begin
					tour_one[cmd.position] = cmd.gene_one;
					tour_two[cmd.position] = cmd.gene_two;
					slot_one[cmd.gene_one] = cmd.position;
					slot_two[cmd.gene_two] = cmd.position;
				end else if (item_typed) begin
					pending_children.push_back(item_want);
				end else begin
					breed_children(cmd.cut_first, cmd.cut_second);
				end
			end
			if (strobe) begin
				if (pending_children.size() == 0) begin
					mismatches++;
					$display("%0t: result beat expected none, got %h", $time, res);
				end else begin
					oldest_child = pending_children.pop_front();
					if (res.out_position !== oldest_child.out_position)
						note_mismatch("out_position", oldest_child.out_position, res.out_position);
					if (res.child_one_gene !== oldest_child.child_one_gene)
						note_mismatch("child_one_gene", oldest_child.child_one_gene,
							res.child_one_gene);
					if (res.child_two_gene !== oldest_child.child_two_gene)
						note_mismatch("child_two_gene", oldest_child.child_two_gene,
							res.child_two_gene);
					if (res.last !== oldest_child.last)
						note_mismatch("last", CITY_W'(oldest_child.last), CITY_W'(res.last));
					if (res.error !== oldest_child.error)
						note_mismatch("error", CITY_W'(oldest_child.error), CITY_W'(res.error));
				end
			end
		end
	end

	function automatic cmd_t load_beat(input int pos, input int gene_a, input int gene_b);
		cmd_t c;
		c.action     = ACT_LOAD;
		c.position   = CITY_W'(pos);
		c.gene_one   = CITY_W'(gene_a);
		c.gene_two   = CITY_W'(gene_b);
		c.cut_first  = CITY_W'($urandom_range(63));
		c.cut_second = CITY_W'($urandom_range(63));
		return c;
	endfunction

	function automatic cmd_t run_beat(input int cut_a, input int cut_b);
		cmd_t c;
		c.action     = ACT_RUN;
		c.position   = CITY_W'($urandom_range(63));
		c.gene_one   = CITY_W'($urandom_range(63));
		c.gene_two   = CITY_W'($urandom_range(63));
		c.cut_first  = CITY_W'(cut_a);
		c.cut_second = CITY_W'(cut_b);
		return c;
	endfunction

	// mostly legal cuts, now and then anywhere in the field
	function automatic int pick_cut(input int n);
		if ($urandom_range(99) < 85)
			return $urandom_range(n - 1);
		return $urandom_range(63);
	endfunction

	task automatic shuffle(inout int vals [MAX_CITIES], input int len);
		int i, j, t;
		for (i = len - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = vals[i];
			vals[i] = vals[j];
			vals[j] = t;
		end
	endtask

	task automatic send_item(input cmd_t beat, input bit typed, input res_t want);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
		end else if (idle_pct > 0 && $urandom_range(15) == 0) begin
			calm_left = $urandom_range(20, 5);
		end else if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			gap = ($urandom_range(7) == 0) ? $urandom_range(150, 10) : $urandom_range(3, 1);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= beat;
		item_typed <= typed;
		item_want <= want;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// two parents over the same random city set, positions loaded in random order
	task automatic load_parents(input int n);
		int cities [MAX_CITIES];
		int second [MAX_CITIES];
		int order [MAX_CITIES];
		int i;
		for (i = 0; i < MAX_CITIES; i++) begin
			cities[i] = i;
			order[i] = i;
		end
		shuffle(cities, MAX_CITIES);
		second = cities;
		shuffle(second, n);
		shuffle(order, n);
		for (i = 0; i < n; i++)
			send_item(load_beat(order[i], cities[order[i]], second[order[i]]), 1'b0, FAILED_RUN);
	endtask

	task automatic write_city_count(input logic [CNT_W-1:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (pending_children.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		city_count = value;
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int n, roll, phase_end, ph, i;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		item_typed = 1'b0;
		item_want = FAILED_RUN;
		idle_pct = 0;
		calm_left = 0;
		items_sent = 0;
		mismatches = 0;
		city_count = CNT_RESET;

		// four-city tours: p1 = 0 1 2 3, p2 = 3 2 1 0
		directed_rows.push_back(row_t'{load_beat(0, 0, 3), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{load_beat(1, 1, 2), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{load_beat(2, 2, 1), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{load_beat(3, 3, 0), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{load_beat(63, 63, 63), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{run_beat(1, 2), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{run_beat(2, 1), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{run_beat(0, 3), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{run_beat(0, 0), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{run_beat(3, 3), 1'b0, FAILED_RUN});
		// cut at or past the city count
		directed_rows.push_back(row_t'{run_beat(4, 0), 1'b1, FAILED_RUN});
		directed_rows.push_back(row_t'{run_beat(1, 63), 1'b1, FAILED_RUN});
		directed_rows.push_back(row_t'{run_beat(63, 63), 1'b1, FAILED_RUN});
		// city 2 at three positions in p1 and mapped onto itself in the segment: walk never ends
		directed_rows.push_back(row_t'{load_beat(0, 2, 3), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{load_beat(1, 2, 2), 1'b0, FAILED_RUN});
		directed_rows.push_back(row_t'{run_beat(1, 1), 1'b1, FAILED_RUN});
		// stale position entries pointing into the segment
		directed_rows.push_back(row_t'{run_beat(2, 0), 1'b0, FAILED_RUN});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_city_count(CNT_W'(4));
		for (i = 0; i < directed_rows.size(); i++)
			send_item(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

		for (ph = 0; ph < 8; ph++) begin
			write_city_count(CNT_W'(plan_count[ph]));
			idle_pct = plan_idle[ph];
			calm_left = 0;
			n = active_cities();
			phase_end = items_sent + plan_items[ph];
			// full load first so that every store and position entry holds a value
			if (ph == 0)
				load_parents(MAX_CITIES);
			while (items_sent < phase_end) begin
				roll = $urandom_range(99);
				if (roll < 70) begin
					load_parents(n);
					repeat ($urandom_range(3, 1))
						send_item(run_beat(pick_cut(n), pick_cut(n)), 1'b0, FAILED_RUN);
				end else if (roll < 90) begin
					// scattered loads break the permutations
					repeat ($urandom_range(4, 1))
						send_item(load_beat(($urandom_range(3) == 0) ? $urandom_range(63) :
							$urandom_range(n - 1), $urandom_range(63), $urandom_range(63)),
							1'b0, FAILED_RUN);
					send_item(run_beat(pick_cut(n), pick_cut(n)), 1'b0, FAILED_RUN);
				end else begin
					send_item(run_beat($urandom_range(63), $urandom_range(63)), 1'b0,
						FAILED_RUN);
				end
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending_children.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_children.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- pmx_crossover_engine.f -----
rtl/pmx_pkg.sv
rtl/pmx_crossover_engine.sv
rtl/pmx_checker.sv
sim/pmx_crossover_engine_test.sv
